>>> rtl/core/rtcdt_pkg.sv
package rtcdt_pkg;

    // Forward wraps needed for the largest local hour (127 + 14 = 141 -> 5 wraps)
    localparam int NUM_CARRY = 5;

    localparam logic [7:0]  BIN_MODE_BIT   = 8'h04;
    localparam logic [7:0]  H24_MODE_BIT   = 8'h02;
    localparam logic [7:0]  PM_BIT         = 8'h80;
    localparam logic [7:0]  HOUR_MASK      = 8'h7F;
    localparam logic [7:0]  CENTURY_PIVOT  = 8'd70;
    localparam logic [11:0] BASE_1900      = 12'd1900;
    localparam logic [11:0] BASE_2000      = 12'd2000;
    localparam logic signed [8:0] HOURS_PER_DAY = 9'sd24;
    localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN   = 17'd60;
    // Only non-leap century year that a 1969..2156 year can reach
    localparam logic [11:0] NON_LEAP_CENTURY = 12'd2100;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic              ok;
        logic [7:0]        second;
        logic [7:0]        minute;
        logic signed [8:0] hr;
        logic [7:0]        day;
        logic [7:0]        month;
        logic [11:0]       year;
    } rtcdt_item_t;

    // Days in a month; an invalid month counts as 31
    function automatic logic [4:0] month_days(logic [11:0] y, logic [7:0] m);
        logic lp;
        lp = (y[1:0] == 2'b00) && (y != NON_LEAP_CENTURY);
        if (m == 8'd2 && lp)
            return 5'd29;
        if (m < 8'd1 || m > 8'd12)
            return 5'd31;
        return MONTH_LEN[m[3:0] - 4'd1];
    endfunction

    // One wrap of the hour by a day, carrying into day, month and year
    function automatic rtcdt_item_t carry_step(rtcdt_item_t a);
        rtcdt_item_t r;
        logic [8:0]  day_inc;
        logic [7:0]  mon_prev;
        logic [11:0] yr_prev;
        r        = a;
        day_inc  = {1'b0, a.day} + 9'd1;
        mon_prev = a.month - 8'd1;
        yr_prev  = a.year;
        if (a.hr >= HOURS_PER_DAY) begin
            r.hr = a.hr - HOURS_PER_DAY;
            if (day_inc > {4'b0, month_days(a.year, a.month)}) begin
                r.day = 8'd1;
                if (a.month >= 8'd12) begin
                    r.month = 8'd1;
                    r.year  = a.year + 12'd1;
                end
                else begin
                    r.month = a.month + 8'd1;
                end
            end
            else begin
                r.day = day_inc[7:0];
            end
        end
        else if (a.hr < 9'sd0) begin
            r.hr = a.hr + HOURS_PER_DAY;
            if (a.day <= 8'd1) begin
                if (a.month <= 8'd1) begin
                    mon_prev = 8'd12;
                    yr_prev  = a.year - 12'd1;
                end
                r.month = mon_prev;
                r.year  = yr_prev;
                r.day   = {3'b0, month_days(yr_prev, mon_prev)};
            end
            else begin
                r.day = a.day - 8'd1;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/rtcdt_carry_stage.sv
module rtcdt_carry_stage
    import rtcdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rtcdt_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output rtcdt_item_t out_item
);

    logic        valid_reg;
    rtcdt_item_t item_reg;
    rtcdt_item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign item_next = carry_step(in_item);

    // Advance the valid bit whenever the stage can move
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Capture one wrap step of the word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> rtl/core/rtc_raw_to_local_datetime_core.sv
// Raw CMOS clock snapshot to local date and time.
// Input channel (in_valid/in_ready) carries one register snapshot as a word:
// read_ok, the raw seconds, minutes, hours, day, month, year registers and
// status B. Output channel (out_valid/out_ready) returns one word per input:
// ok, second, minute, hour, day, month, year and seconds_of_day.
// The APB port holds tz_offset at address 0; writes are clamped to -12..14.
// The path has seven register stages: one decode stage, five carry stages
// (one wrap of the hour by 24 each, enough for the largest local hour) and
// one output stage that forms seconds_of_day. It takes one word per cycle
// while out_ready stays high; every stage has its own valid bit.
// When the receiver holds out_ready low the output word holds and the
// stages behind it fill up, then in_ready drops; nothing is lost or repeated.
// Reset empties every stage and sets tz_offset to 0.
// A failed read (read_ok low) gives ok 0 with every other field zero.
module rtc_raw_to_local_datetime_core
    import rtcdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        read_ok,
    input  logic [7:0]  raw_second,
    input  logic [7:0]  raw_minute,
    input  logic [7:0]  raw_hr,
    input  logic [7:0]  raw_day,
    input  logic [7:0]  raw_month,
    input  logic [7:0]  raw_year,
    input  logic [7:0]  raw_status,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [7:0]  second,
    output logic [7:0]  minute,
    output logic [4:0]  hour,
    output logic [7:0]  day,
    output logic [7:0]  month,
    output logic [11:0] year,
    output logic [16:0] seconds_of_day
);

    function automatic logic [7:0] bcd_value(logic [7:0] v);
        return {4'b0, v[3:0]} + {4'b0, v[7:4]} * 8'd10;
    endfunction

    logic signed [4:0] tz_offset_reg;
    logic signed [4:0] tz_offset_next;
    logic signed [4:0] tz_wr;
    logic              cfg_wr;

    rtcdt_item_t dec_next;
    rtcdt_item_t stage_item  [NUM_CARRY+1];
    logic        stage_valid [NUM_CARRY+1];
    logic        stage_ready [NUM_CARRY+1];
    logic        dec_valid_reg;
    rtcdt_item_t dec_item_reg;

    logic        out_valid_reg;
    logic        out_ok_reg;
    logic [7:0]  out_second_reg;
    logic [7:0]  out_minute_reg;
    logic [4:0]  out_hour_reg;
    logic [7:0]  out_day_reg;
    logic [7:0]  out_month_reg;
    logic [11:0] out_year_reg;
    logic [16:0] out_sod_reg;
    logic [16:0] out_sod_next;
    logic [4:0]  last_hr;

    // Configuration: clamp and hold the timezone offset
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign tz_wr  = $signed(pwdata[4:0]);

    always_comb
    begin
        tz_offset_next = tz_offset_reg;
        if (cfg_wr) begin
            priority if (tz_wr < -5'sd12)
                tz_offset_next = -5'sd12;
            else if (tz_wr > 5'sd14)
                tz_offset_next = 5'sd14;
            else
                tz_offset_next = tz_wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tz_offset_reg <= 5'sd0;
        else
            tz_offset_reg <= tz_offset_next;
    end

    assign prdata = (paddr[2] == 1'b0) ? {{27{tz_offset_reg[4]}}, tz_offset_reg} : 32'd0;

    // Decode: BCD or binary, 12-hour to 24-hour, century, add offset
    always_comb
    begin
        logic       binary;
        logic       h24;
        logic       pm;
        logic [7:0] rh;
        logic [7:0] hr_dec;
        logic [7:0] yy;
        binary = (raw_status & BIN_MODE_BIT) != 8'd0;
        h24    = (raw_status & H24_MODE_BIT) != 8'd0;
        pm     = !h24 && ((raw_hr & PM_BIT) != 8'd0);
        rh     = raw_hr & HOUR_MASK;
        dec_next = '0;
        if (binary) begin
            dec_next.second = raw_second;
            dec_next.minute = raw_minute;
            hr_dec          = rh;
            dec_next.day    = raw_day;
            dec_next.month  = raw_month;
            yy              = raw_year;
        end
        else begin
            dec_next.second = bcd_value(raw_second);
            dec_next.minute = bcd_value(raw_minute);
            hr_dec          = bcd_value(rh);
            dec_next.day    = bcd_value(raw_day);
            dec_next.month  = bcd_value(raw_month);
            yy              = bcd_value(raw_year);
        end
        if (!h24) begin
            if (pm && hr_dec < 8'd12)
                hr_dec = hr_dec + 8'd12;
            else if (!pm && hr_dec == 8'd12)
                hr_dec = 8'd0;
        end
        dec_next.year = (yy >= CENTURY_PIVOT) ? BASE_1900 + {4'b0, yy}
                                              : BASE_2000 + {4'b0, yy};
        dec_next.hr   = $signed({1'b0, hr_dec}) + $signed({{4{tz_offset_reg[4]}}, tz_offset_reg});
        dec_next.ok   = 1'b1;
        // Drop a failed read to an all-zero word
        if (!read_ok)
            dec_next = '0;
    end

    assign in_ready = !dec_valid_reg || stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_valid_reg <= 1'b0;
        else if (in_ready)
            dec_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            dec_item_reg <= dec_next;
    end

    assign stage_valid[0] = dec_valid_reg;
    assign stage_item[0]  = dec_item_reg;

    // Carry chain: one wrap per stage
    for (genvar k = 0; k < NUM_CARRY; k++) begin : g_carry
        rtcdt_carry_stage u_carry (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_item   (stage_item[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_item  (stage_item[k+1])
        );
    end

    // Output stage: form seconds of the day and hold the result word
    assign stage_ready[NUM_CARRY] = !out_valid_reg || out_ready;
    assign last_hr = stage_item[NUM_CARRY].hr[4:0];
    assign out_sod_next = {12'b0, last_hr} * SECS_PER_HOUR
                        + {9'b0, stage_item[NUM_CARRY].minute} * SECS_PER_MIN
                        + {9'b0, stage_item[NUM_CARRY].second};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_ready[NUM_CARRY])
            out_valid_reg <= stage_valid[NUM_CARRY];
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid[NUM_CARRY] && stage_ready[NUM_CARRY]) begin
            out_ok_reg     <= stage_item[NUM_CARRY].ok;
            out_second_reg <= stage_item[NUM_CARRY].second;
            out_minute_reg <= stage_item[NUM_CARRY].minute;
            out_hour_reg   <= last_hr;
            out_day_reg    <= stage_item[NUM_CARRY].day;
            out_month_reg  <= stage_item[NUM_CARRY].month;
            out_year_reg   <= stage_item[NUM_CARRY].year;
            out_sod_reg    <= out_sod_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = out_ok_reg;
    assign second         = out_second_reg;
    assign minute         = out_minute_reg;
    assign hour           = out_hour_reg;
    assign day            = out_day_reg;
    assign month          = out_month_reg;
    assign year           = out_year_reg;
    assign seconds_of_day = out_sod_reg;

endmodule

>>> rtl/core/rtcdt_checker.sv
module rtcdt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic [2:0]  paddr,
    input logic [31:0] prdata,
    input logic        out_valid,
    input logic        out_ready,
    input logic        ok,
    input logic [7:0]  second,
    input logic [7:0]  minute,
    input logic [4:0]  hour,
    input logic [7:0]  day,
    input logic [7:0]  month,
    input logic [11:0] year,
    input logic [16:0] seconds_of_day
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(year) && $stable(seconds_of_day))
        else $error("stalled result word changed");

    // Failed read gives an all-zero word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> second == 8'd0 && minute == 8'd0 && hour == 5'd0
            && day == 8'd0 && month == 8'd0 && year == 12'd0 && seconds_of_day == 17'd0)
        else $error("failed read word not zero");

    // Local hour is wrapped into a day
    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> hour < 5'd24)
        else $error("local hour out of range");

    // Seconds of the day agree with the time fields
    a_sod: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seconds_of_day == {12'b0, hour} * 17'd3600
            + {9'b0, minute} * 17'd60 + {9'b0, second})
        else $error("seconds of day inconsistent");

    // Offset register reads back within its clamp range
    a_tz_range: assert property (@(posedge clk) disable iff (!rst_n)
        psel && paddr[2] == 1'b0 |-> $signed(prdata) >= -32'sd12 && $signed(prdata) <= 32'sd14)
        else $error("timezone offset out of range");

endmodule

bind rtc_raw_to_local_datetime_core rtcdt_checker u_rtcdt_checker (.*);

>>> bench/rtcdt_datetime_checker.sv
module rtcdt_datetime_checker
    import rtcdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        read_ok,
    input  logic [7:0]  raw_second,
    input  logic [7:0]  raw_minute,
    input  logic [7:0]  raw_hr,
    input  logic [7:0]  raw_day,
    input  logic [7:0]  raw_month,
    input  logic [7:0]  raw_year,
    input  logic [7:0]  raw_status,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        ok,
    input  logic [7:0]  second,
    input  logic [7:0]  minute,
    input  logic [4:0]  hour,
    input  logic [7:0]  day,
    input  logic [7:0]  month,
    input  logic [11:0] year,
    input  logic [16:0] seconds_of_day,
    output int          failures,
    output int          pending,
    output int          words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] TZ_ADDR   = 3'd0;
    localparam int         TZ_MIN    = -12;
    localparam int         TZ_MAX    = 14;
    localparam int         DAY_HOURS = 24;
    localparam int         SECS_HOUR = 3600;
    localparam int         SECS_MIN  = 60;

    typedef struct packed {
        logic        ok;
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [4:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [11:0] year;
        logic [16:0] seconds_of_day;
    } local_time_t;

    local_time_t local_time_q[$];
    local_time_t want;
    int          tz_hours;
    int          tz_next;

    function automatic logic leap_year(int y);
        if ((y % 400) == 0)
            return 1'b1;
        if ((y % 100) == 0)
            return 1'b0;
        return (y % 4) == 0;
    endfunction

    // Month length; anything outside 1..12 counts as a long month
    function automatic int month_length(int y, int m);
        if (m == 2 && leap_year(y))
            return 29;
        if (m < 1 || m > 12)
            return 31;
        case (m)
            2:              return 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    function automatic int reg_value(logic [7:0] v, logic binary);
        if (binary)
            return int'(v);
        return int'(v[3:0]) + 10 * int'(v[7:4]);
    endfunction

    function automatic local_time_t predict_local_time(
        logic rd_ok, logic [7:0] s, logic [7:0] mi, logic [7:0] h, logic [7:0] d,
        logic [7:0] mo, logic [7:0] y, logic [7:0] sb, int tz);
        local_time_t r;
        logic        binary;
        logic        h24;
        logic        pm;
        int          sec;
        int          mn;
        int          hr;
        int          dy;
        int          mon;
        int          yy;
        int          yr;
        int          sod;
        r = '0;
        if (!rd_ok)
            return r;
        binary = (sb & BIN_MODE_BIT) != 8'd0;
        h24    = (sb & H24_MODE_BIT) != 8'd0;
        pm     = !h24 && ((h & PM_BIT) != 8'd0);
        sec    = reg_value(s, binary);
        mn     = reg_value(mi, binary);
        hr     = reg_value(h & HOUR_MASK, binary);
        dy     = reg_value(d, binary);
        mon    = reg_value(mo, binary);
        yy     = reg_value(y, binary);
        // fold 12-hour time into 24-hour form
        if (!h24) begin
            if (pm && hr < 12)
                hr += 12;
            if (!pm && hr == 12)
                hr = 0;
        end
        yr = (yy >= int'(CENTURY_PIVOT)) ? int'(BASE_1900) + yy : int'(BASE_2000) + yy;
        // apply the offset and carry each whole day into the date
        hr += tz;
        while (hr >= DAY_HOURS) begin
            hr -= DAY_HOURS;
            dy++;
            if (dy > month_length(yr, mon)) begin
                dy = 1;
                mon++;
                if (mon > 12) begin
                    mon = 1;
                    yr++;
                end
            end
        end
        while (hr < 0) begin
            hr += DAY_HOURS;
            dy--;
            if (dy < 1) begin
                mon--;
                if (mon < 1) begin
                    mon = 12;
                    yr--;
                end
                dy = month_length(yr, mon);
            end
        end
        sod              = hr * SECS_HOUR + mn * SECS_MIN + sec;
        r.ok             = 1'b1;
        r.second         = sec[7:0];
        r.minute         = mn[7:0];
        r.hour           = hr[4:0];
        r.day            = dy[7:0];
        r.month          = mon[7:0];
        r.year           = yr[11:0];
        r.seconds_of_day = sod[16:0];
        return r;
    endfunction

    task automatic check_field(string name, int expected, int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            failures++;
        end
    endtask

    // Track the offset register, predict each accepted word, compare each result word
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tz_hours = 0;
            local_time_q.delete();
            failures      = 0;
            words_checked = 0;
            pending <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == TZ_ADDR) begin
                tz_next = int'($signed(pwdata[4:0]));
                if (tz_next < TZ_MIN)
                    tz_next = TZ_MIN;
                if (tz_next > TZ_MAX)
                    tz_next = TZ_MAX;
                tz_hours = tz_next;
            end
            if (in_valid && in_ready)
                local_time_q.push_back(predict_local_time(read_ok, raw_second, raw_minute,
                    raw_hr, raw_day, raw_month, raw_year, raw_status, tz_hours));
            if (out_valid && out_ready) begin
                if (local_time_q.size() == 0) begin
                    $error("result word arrived with no prediction waiting");
                    failures++;
                end
                else begin
                    want = local_time_q.pop_front();
                    check_field("ok", int'(want.ok), int'(ok));
                    check_field("second", int'(want.second), int'(second));
                    check_field("minute", int'(want.minute), int'(minute));
                    check_field("hour", int'(want.hour), int'(hour));
                    check_field("day", int'(want.day), int'(day));
                    check_field("month", int'(want.month), int'(month));
                    check_field("year", int'(want.year), int'(year));
                    check_field("seconds_of_day", int'(want.seconds_of_day),
                                int'(seconds_of_day));
                    words_checked++;
                end
            end
            pending <= local_time_q.size();
        end
    end

endmodule

>>> bench/testbench.sv
module testbench
    import rtcdt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_HALF        = 6;
    localparam int         RESET_CYCLES    = 5;
    localparam int         PIPE_LATENCY    = 7;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         IDLE_PCT        = 29;
    localparam int         NOISE_PCT       = 25;
    localparam int         RANDOM_PHASES   = 10;
    localparam int         WORDS_PER_PHASE = 110;
    localparam int         STEADY_PHASE    = 4;
    localparam logic [2:0] TZ_ADDR         = 3'd0;
    localparam logic [2:0] SPARE_ADDR      = 3'd4;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic        read_ok    = 1'b0;
    logic [7:0]  raw_second = '0;
    logic [7:0]  raw_minute = '0;
    logic [7:0]  raw_hr     = '0;
    logic [7:0]  raw_day    = '0;
    logic [7:0]  raw_month  = '0;
    logic [7:0]  raw_year   = '0;
    logic [7:0]  raw_status = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic        ok;
    logic [7:0]  second;
    logic [7:0]  minute;
    logic [4:0]  hour;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [11:0] year;
    logic [16:0] seconds_of_day;

    int   failures;
    int   pending;
    int   words_checked;
    int   words_sent  = 0;
    int   tz_writes   = 0;
    int   cycle_count = 0;
    logic steady      = 1'b0;
    int   phase;

    rtc_raw_to_local_datetime_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .read_ok        (read_ok),
        .raw_second     (raw_second),
        .raw_minute     (raw_minute),
        .raw_hr         (raw_hr),
        .raw_day        (raw_day),
        .raw_month      (raw_month),
        .raw_year       (raw_year),
        .raw_status     (raw_status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .second         (second),
        .minute         (minute),
        .hour           (hour),
        .day            (day),
        .month          (month),
        .year           (year),
        .seconds_of_day (seconds_of_day)
    );

    rtcdt_datetime_checker u_datetime_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .read_ok        (read_ok),
        .raw_second     (raw_second),
        .raw_minute     (raw_minute),
        .raw_hr         (raw_hr),
        .raw_day        (raw_day),
        .raw_month      (raw_month),
        .raw_year       (raw_year),
        .raw_status     (raw_status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .second         (second),
        .minute         (minute),
        .hour           (hour),
        .day            (day),
        .month          (month),
        .year           (year),
        .seconds_of_day (seconds_of_day),
        .failures       (failures),
        .pending        (pending),
        .words_checked  (words_checked)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Stall the result side at random, except during the steady phase
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tz_writes++;
    endtask

    // Offer one snapshot word, idling at random beforehand, and hold it until taken
    task automatic send_word(logic rd_ok, logic [7:0] s, logic [7:0] mi, logic [7:0] h,
                             logic [7:0] d, logic [7:0] mo, logic [7:0] y, logic [7:0] sb);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        read_ok    <= rd_ok;
        raw_second <= s;
        raw_minute <= mi;
        raw_hr     <= h;
        raw_day    <= d;
        raw_month  <= mo;
        raw_year   <= y;
        raw_status <= sb;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (PIPE_LATENCY + 3) @(posedge clk);
    endtask

    task automatic set_offset(logic [31:0] value);
        settle();
        write_reg(TZ_ADDR, value);
    endtask

    function automatic logic [7:0] encode_reg(int v, logic binary);
        if (binary)
            return v[7:0];
        return 8'(((v / 10) << 4) + (v % 10));
    endfunction

    // Mostly well-formed snapshots near month ends, the rest raw noise
    task automatic send_random_word();
        logic       binary;
        logic       h24;
        logic       pm;
        int         hr;
        int         dy;
        logic [7:0] sb;
        logic [7:0] raw_h;
        if ($urandom_range(0, 99) < NOISE_PCT) begin
            send_word(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        else begin
            binary = 1'($urandom_range(0, 1));
            h24    = 1'($urandom_range(0, 1));
            pm     = 1'($urandom_range(0, 1));
            sb     = 8'($urandom) & ~(BIN_MODE_BIT | H24_MODE_BIT);
            if (binary)
                sb |= BIN_MODE_BIT;
            if (h24)
                sb |= H24_MODE_BIT;
            hr    = h24 ? $urandom_range(0, 23) : $urandom_range(1, 12);
            raw_h = encode_reg(hr, binary);
            // the top bit means PM only in 12-hour mode; otherwise it must be ignored
            if (pm)
                raw_h |= PM_BIT;
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 4))
                    0:       dy = 1;
                    1:       dy = 28;
                    2:       dy = 29;
                    3:       dy = 30;
                    default: dy = 31;
                endcase
            end
            else begin
                dy = $urandom_range(1, 31);
            end
            send_word($urandom_range(0, 99) < 95,
                      encode_reg($urandom_range(0, 59), binary),
                      encode_reg($urandom_range(0, 59), binary),
                      raw_h,
                      encode_reg(dy, binary),
                      encode_reg($urandom_range(1, 12), binary),
                      encode_reg($urandom_range(0, 99), binary),
                      sb);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero offset: decoding, hour modes, century pivot
        write_reg(TZ_ADDR, 32'd0);
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(1'b1, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, H24_MODE_BIT);
        send_word(1'b1, 8'h00, 8'h00, 8'h12, 8'h15, 8'h06, 8'h24, 8'h00);
        send_word(1'b1, 8'h30, 8'h45, 8'h92, 8'h15, 8'h06, 8'h24, 8'h00);
        send_word(1'b1, 8'h01, 8'h02, 8'h81, 8'h15, 8'h06, 8'h24, 8'h00);
        send_word(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  BIN_MODE_BIT | H24_MODE_BIT);
        send_word(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, BIN_MODE_BIT);
        send_word(1'b1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h69, H24_MODE_BIT);
        send_word(1'b1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, H24_MODE_BIT);
        send_word(1'b1, 8'hAF, 8'hFA, 8'h3C, 8'hEE, 8'h1F, 8'hD7, 8'hF9);

        // largest positive offset: forward carries into month and year
        set_offset(32'd14);
        send_word(1'b1, 8'h10, 8'h20, 8'h23, 8'h31, 8'h12, 8'h99, H24_MODE_BIT);
        send_word(1'b1, 8'd0, 8'd0, 8'd23, 8'd28, 8'd2, 8'd200,
                  BIN_MODE_BIT | H24_MODE_BIT);
        send_word(1'b1, 8'h00, 8'h00, 8'h20, 8'h28, 8'h02, 8'h24, H24_MODE_BIT);
        send_word(1'b1, 8'd5, 8'd6, 8'd20, 8'd31, 8'd13, 8'd30,
                  BIN_MODE_BIT | H24_MODE_BIT);
        send_word(1'b1, 8'd5, 8'd6, 8'd20, 8'd31, 8'd0, 8'd30,
                  BIN_MODE_BIT | H24_MODE_BIT);
        send_word(1'b1, 8'd5, 8'd6, 8'd20, 8'd255, 8'd5, 8'd30,
                  BIN_MODE_BIT | H24_MODE_BIT);

        // largest negative offset: backward carries
        set_offset(32'h14);
        send_word(1'b1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, H24_MODE_BIT);
        send_word(1'b1, 8'h00, 8'h00, 8'h05, 8'h01, 8'h03, 8'h24, H24_MODE_BIT);
        send_word(1'b1, 8'd0, 8'd0, 8'd5, 8'd1, 8'd3, 8'd200, BIN_MODE_BIT | H24_MODE_BIT);
        send_word(1'b1, 8'd0, 8'd0, 8'd5, 8'd1, 8'd0, 8'd40, BIN_MODE_BIT | H24_MODE_BIT);
        send_word(1'b1, 8'd0, 8'd0, 8'd5, 8'd0, 8'd7, 8'd40, BIN_MODE_BIT | H24_MODE_BIT);
        send_word(1'b1, 8'd0, 8'd0, 8'd5, 8'd1, 8'd200, 8'd40,
                  BIN_MODE_BIT | H24_MODE_BIT);
        send_word(1'b1, 8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h00, 8'h00);

        // writes outside the range clamp; a write to the spare address changes nothing
        set_offset(32'h0F);
        send_word(1'b1, 8'h00, 8'h00, 8'h11, 8'h30, 8'h04, 8'h12, H24_MODE_BIT);
        set_offset(32'hFFFF_FFF0);
        send_word(1'b1, 8'h00, 8'h00, 8'h03, 8'h01, 8'h05, 8'h12, H24_MODE_BIT);
        settle();
        write_reg(SPARE_ADDR, 32'h0000_0005);
        send_word(1'b1, 8'h00, 8'h00, 8'h03, 8'h01, 8'h05, 8'h12, H24_MODE_BIT);

        // random phases, each under its own offset
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       set_offset(32'd14);
                1:       set_offset(32'h14);
                2:       set_offset(32'h0F);
                3:       set_offset(32'h10);
                default: set_offset($urandom);
            endcase
            if ($urandom_range(0, 3) == 0) begin
                @(posedge clk);
                write_reg(SPARE_ADDR, $urandom);
            end
            steady <= (phase == STEADY_PHASE);
            repeat (WORDS_PER_PHASE) send_random_word();
        end
        settle();

        $display("Sent %0d snapshot words across %0d register writes, offsets -12 to +14",
                 words_sent, tz_writes);
        $display("Compared %0d local date and time words", words_checked);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
